@@ sv/pcfs_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the periodic frame scheduler
// no dependencies; imported by every module of the block

package pcfs_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FAULT_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENGINE_PER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_PER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HB_PER      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENGINE_ID   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_ID     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HB_ID       = 3'd6;

	// fault modes
	localparam logic [1:0] FAULT_NONE      = 2'd0;
	localparam logic [1:0] FAULT_STOP      = 2'd1;
	localparam logic [1:0] FAULT_WRONG_VAL = 2'd2;
	localparam logic [1:0] FAULT_WRONG_LEN = 2'd3;

	// register reset values
	localparam logic [15:0] ENGINE_PER_RST = 16'd20;
	localparam logic [15:0] TEMP_PER_RST   = 16'd200;
	localparam logic [15:0] HB_PER_RST     = 16'd100;
	localparam logic [10:0] ENGINE_ID_RST  = 11'd256;
	localparam logic [10:0] TEMP_ID_RST    = 11'd257;
	localparam logic [10:0] HB_ID_RST      = 11'd258;

	// stream bit positions in the fire mask
	localparam int STR_ENGINE = 0;
	localparam int STR_TEMP   = 1;
	localparam int STR_HB     = 2;
	localparam int NUM_STR    = 3;

	// payload ramps and fault values
	localparam logic [15:0] RPM_RESET  = 16'd1000;
	localparam logic [15:0] RPM_STEP   = 16'd50;
	localparam logic [15:0] RPM_LIMIT  = 16'd4000;
	localparam logic [15:0] RPM_FAULT  = 16'd8000;
	localparam logic [7:0]  TEMP_RESET = 8'd50;
	localparam logic [7:0]  TEMP_STEP  = 8'd5;
	localparam logic [7:0]  TEMP_LIMIT = 8'd150;
	localparam logic [7:0]  TEMP_FAULT = 8'd200;
	localparam logic [7:0]  HB_BYTE    = 8'hAA;
	localparam logic [7:0]  HB_FAULT   = 8'hBB;

	// data length codes
	localparam logic [3:0] LEN_ONE = 4'd1;
	localparam logic [3:0] LEN_TWO = 4'd2;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	typedef struct packed {
		logic [15:0] engine_period;
		logic [15:0] temp_period;
		logic [15:0] hb_period;
		logic [10:0] engine_id;
		logic [10:0] temp_id;
		logic [10:0] hb_id;
		logic [1:0]  fault_mode;
	} cfg_t;

	// one classified poll: which streams fired and their payloads
	typedef struct packed {
		logic [NUM_STR-1:0] fire;
		logic [15:0]        rpm;
		logic [7:0]         temp;
		logic               wrong_val;
		logic               wrong_len;
	} bundle_t;

endpackage

@@ sv/pcfs_front.sv @@
`timescale 1ns / 1ps
// front end: takes polls, advances wait counters and payload ramps,
// and pushes one bundle per poll that fires anything; uses pcfs_pkg

module pcfs_front #(
	parameter int TIMER_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pcfs_pkg::cfg_t   cfg,
	input  logic             poll_valid,
	output logic             poll_ready,
	input  logic [7:0]       elapsed_ticks,
	input  logic             q_full,
	output logic             q_push,
	output pcfs_pkg::bundle_t q_data
);
	import pcfs_pkg::*;

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	logic [TIMER_BITS-1:0] engine_wait_q, temp_wait_q, hb_wait_q;
	logic [TIMER_BITS-1:0] engine_grown, temp_grown, hb_grown;
	logic [15:0]           rpm_q, rpm_inc, rpm_next;
	logic [7:0]            temp_q, temp_inc, temp_next;
	logic [NUM_STR-1:0]    fire;
	logic                  accept, stop, wrong_val, wrong_len;

	// saturating add of the elapsed ticks
	function automatic logic [TIMER_BITS-1:0] grow(input logic [TIMER_BITS-1:0] w,
		input logic [7:0] d);
		logic [TIMER_BITS:0] sum;
		sum = {1'b0, w} + (TIMER_BITS+1)'(d);
		return sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
	endfunction

	function automatic logic reached(input logic [TIMER_BITS-1:0] w, input logic [15:0] p);
		return CMP_W'(w) >= CMP_W'(p);
	endfunction

	assign poll_ready = !q_full;
	assign accept     = poll_valid && poll_ready;
	assign stop       = (cfg.fault_mode == FAULT_STOP);
	assign wrong_val  = (cfg.fault_mode == FAULT_WRONG_VAL);
	assign wrong_len  = (cfg.fault_mode == FAULT_WRONG_LEN);

	// classify the poll
	always_comb begin
		engine_grown = grow(engine_wait_q, elapsed_ticks);
		temp_grown   = grow(temp_wait_q, elapsed_ticks);
		hb_grown     = grow(hb_wait_q, elapsed_ticks);
		fire[STR_ENGINE] = !stop && reached(engine_grown, cfg.engine_period);
		fire[STR_TEMP]   = !stop && reached(temp_grown, cfg.temp_period);
		fire[STR_HB]     = !stop && reached(hb_grown, cfg.hb_period);
	end

	// payload ramps
	always_comb begin
		rpm_inc  = rpm_q + RPM_STEP;
		temp_inc = temp_q + TEMP_STEP;
		if (wrong_val) begin
			rpm_next  = RPM_FAULT;
			temp_next = TEMP_FAULT;
		end else begin
			rpm_next  = (rpm_inc >= RPM_LIMIT) ? RPM_RESET : rpm_inc;
			temp_next = (temp_inc >= TEMP_LIMIT) ? TEMP_RESET : temp_inc;
		end
	end

	// state update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engine_wait_q <= '0;
			temp_wait_q   <= '0;
			hb_wait_q     <= '0;
			rpm_q         <= RPM_RESET;
			temp_q        <= TEMP_RESET;
		end else if (accept) begin
			engine_wait_q <= fire[STR_ENGINE] ? '0 : engine_grown;
			temp_wait_q   <= fire[STR_TEMP] ? '0 : temp_grown;
			hb_wait_q     <= fire[STR_HB] ? '0 : hb_grown;
			if (fire[STR_ENGINE]) begin
				rpm_q <= rpm_next;
			end
			if (fire[STR_TEMP]) begin
				temp_q <= temp_next;
			end
		end
	end

	// hand the bundle to the queue
	assign q_push           = accept && (fire != '0);
	assign q_data.fire      = fire;
	assign q_data.rpm       = fire[STR_ENGINE] ? rpm_next : rpm_q;
	assign q_data.temp      = fire[STR_TEMP] ? temp_next : temp_q;
	assign q_data.wrong_val = wrong_val;
	assign q_data.wrong_len = wrong_len;

endmodule

@@ sv/pcfs_queue.sv @@
`timescale 1ns / 1ps
// short register queue of classified polls between front and back
// uses pcfs_pkg for the bundle type and depth

module pcfs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcfs_pkg::bundle_t wr_data,
	output logic              full,
	input  logic              pop,
	output logic              rd_valid,
	output pcfs_pkg::bundle_t rd_data
);
	import pcfs_pkg::*;

	localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QDEPTH - 1);

	bundle_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/pcfs_back.sv @@
`timescale 1ns / 1ps
// back end: splits each bundle into frames, one beat per cycle while
// frame_ready holds, through an output register; uses pcfs_pkg

module pcfs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pcfs_pkg::cfg_t    cfg,
	input  logic              q_valid,
	input  pcfs_pkg::bundle_t q_data,
	output logic              q_pop,
	output logic              frame_valid,
	input  logic              frame_ready,
	output logic [10:0]       frame_id,
	output logic [3:0]        frame_length,
	output logic [7:0]        data_byte0,
	output logic [7:0]        data_byte1,
	output logic              last_frame
);
	import pcfs_pkg::*;

	bundle_t            cur_q;
	logic [NUM_STR-1:0] mask_q, pick, rest;
	logic               out_valid_q, advance, emit;
	logic [10:0]        id_d;
	logic [3:0]         len_d;
	logic [7:0]         b0_d, b1_d;

	assign advance = !out_valid_q || frame_ready;
	assign emit    = advance && (mask_q != '0);

	// pick the lowest pending stream
	always_comb begin
		pick = mask_q & (~mask_q + NUM_STR'(1));
		rest = mask_q & ~pick;
	end

	assign q_pop = q_valid && ((mask_q == '0) || (emit && (rest == '0)));

	// frame contents for the picked stream
	always_comb begin
		if (pick[STR_ENGINE]) begin
			id_d  = cfg.engine_id;
			len_d = cur_q.wrong_len ? LEN_ONE : LEN_TWO;
			b0_d  = cur_q.rpm[7:0];
			b1_d  = cur_q.rpm[15:8];
		end else if (pick[STR_TEMP]) begin
			id_d  = cfg.temp_id;
			len_d = cur_q.wrong_len ? LEN_TWO : LEN_ONE;
			b0_d  = cur_q.temp;
			b1_d  = '0;
		end else begin
			id_d  = cfg.hb_id;
			len_d = cur_q.wrong_len ? LEN_TWO : LEN_ONE;
			b0_d  = cur_q.wrong_val ? HB_FAULT : HB_BYTE;
			b1_d  = '0;
		end
	end

	// current bundle and pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (q_pop) begin
			mask_q <= q_data.fire;
		end else if (emit) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_id     <= id_d;
			frame_length <= len_d;
			data_byte0   <= b0_d;
			data_byte1   <= b1_d;
			last_frame   <= (rest == '0);
		end
	end

	assign frame_valid = out_valid_q;

endmodule

@@ sv/periodic_can_frame_scheduler.sv @@
`timescale 1ns / 1ps
// periodic frame scheduler top: config registers, front, queue, back
// path: a poll's bundle goes into the queue, then the back's pending mask, then the output register
// throughput: one poll per cycle while the two-entry queue has room; frames
// leave at one beat per cycle while frame_ready holds, one frame per fired stream
// reset: arst_n clears counters, queue and output valid; ramps and registers take defaults
// depends on pcfs_pkg, pcfs_front, pcfs_queue, pcfs_back

module periodic_can_frame_scheduler #(
	parameter int TIMER_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pcfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcfs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           poll_valid,
	output logic                           poll_ready,
	input  logic [7:0]                     elapsed_ticks,
	output logic                           frame_valid,
	input  logic                           frame_ready,
	output logic [10:0]                    frame_id,
	output logic [3:0]                     frame_length,
	output logic [7:0]                     data_byte0,
	output logic [7:0]                     data_byte1,
	output logic                           last_frame
);
	import pcfs_pkg::*;

	cfg_t    cfg_q;
	bundle_t push_data, head_data;
	logic    q_push, q_full, q_pop, q_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fault_mode    <= FAULT_NONE;
			cfg_q.engine_period <= ENGINE_PER_RST;
			cfg_q.temp_period   <= TEMP_PER_RST;
			cfg_q.hb_period     <= HB_PER_RST;
			cfg_q.engine_id     <= ENGINE_ID_RST;
			cfg_q.temp_id       <= TEMP_ID_RST;
			cfg_q.hb_id         <= HB_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FAULT_MODE: cfg_q.fault_mode    <= cfg_data[1:0];
				REG_ENGINE_PER: cfg_q.engine_period <= cfg_data;
				REG_TEMP_PER:   cfg_q.temp_period   <= cfg_data;
				REG_HB_PER:     cfg_q.hb_period     <= cfg_data;
				REG_ENGINE_ID:  cfg_q.engine_id     <= cfg_data[10:0];
				REG_TEMP_ID:    cfg_q.temp_id       <= cfg_data[10:0];
				REG_HB_ID:      cfg_q.hb_id         <= cfg_data[10:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	pcfs_front #(
		.TIMER_BITS(TIMER_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.poll_valid   (poll_valid),
		.poll_ready   (poll_ready),
		.elapsed_ticks(elapsed_ticks),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (push_data)
	);

	pcfs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (push_data),
		.full    (q_full),
		.pop     (q_pop),
		.rd_valid(q_valid),
		.rd_data (head_data)
	);

	pcfs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_data      (head_data),
		.q_pop       (q_pop),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_id    (frame_id),
		.frame_length(frame_length),
		.data_byte0  (data_byte0),
		.data_byte1  (data_byte1),
		.last_frame  (last_frame)
	);

	// queue never written while full
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue written while full");

	// stopped mode sends nothing to the back
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_q.fault_mode == FAULT_STOP) |-> !q_push)
		else $error("bundle pushed in stop mode");

	// a poll's frames leave without gaps
	assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && frame_ready && !last_frame) |=> frame_valid)
		else $error("gap inside a poll's frames");

	// bundles in the queue always carry at least one frame
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (head_data.fire != '0))
		else $error("empty bundle popped");

endmodule
